FILE: hw/rtl/salct_pkg.sv
// ----------------------------------------------------------------------------
// salct_pkg
// Shared types and codes for the set-associative LRU cache tracker.
// ----------------------------------------------------------------------------
package salct_pkg;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2,
    OP_FETCH  = 2'd3
  } op_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 5;

  localparam logic [CfgIdxW-1:0] CFG_SET_BITS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_OFF_BITS = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_WAYS     = 2'd2;

  localparam int unsigned CountW = 32;

  typedef struct packed {
    logic hit;
    logic evict;
    logic modify;
  } upd_t;

endpackage

FILE: hw/rtl/salct_set_mem.sv
// ----------------------------------------------------------------------------
// salct_set_mem
// Set memory: one row per set, all ways side by side, with a registered read.
// Per-row valid bits make rows never written read as zero.
// ----------------------------------------------------------------------------
module salct_set_mem #(
  parameter int unsigned NumSets = 64,
  parameter int unsigned IdxW    = 6,
  parameter int unsigned RowW    = 204
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_idx_i,
  output logic [RowW-1:0] rd_row_o,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_idx_i,
  input  logic [RowW-1:0] wr_row_i
);

  logic [RowW-1:0]    mem [NumSets];
  logic [NumSets-1:0] row_vld_q;
  logic [RowW-1:0]    rd_row_q;
  logic               rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_row_i;
    end
    if (rd_en_i) begin
      rd_row_q <= mem[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_vld_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= row_vld_q[rd_idx_i];
      end
    end
  end

  assign rd_row_o = rd_vld_q ? rd_row_q : '0;

endmodule

FILE: hw/rtl/salct_lru.sv
// ----------------------------------------------------------------------------
// salct_lru
// Tag compare across the in-use ways, victim choice and recency update of
// one set row.
// ----------------------------------------------------------------------------
module salct_lru #(
  parameter int unsigned Ways  = 4,
  parameter int unsigned TagW  = 48,
  parameter int unsigned RankW = 2,
  parameter int unsigned NumW  = 3
) (
  input  logic [Ways*(1+TagW+RankW)-1:0] row_i,
  input  logic [TagW-1:0]                tag_i,
  input  logic [NumW-1:0]                n_i,
  output logic [Ways*(1+TagW+RankW)-1:0] row_o,
  output logic                           hit_o,
  output logic                           evict_o
);

  localparam int unsigned LineW = 1 + TagW + RankW;

  logic [Ways-1:0]  v;
  logic [TagW-1:0]  t [Ways];
  logic [RankW-1:0] r [Ways];
  logic [Ways-1:0]  in_use;
  logic [Ways-1:0]  hit_vec;
  logic [Ways-1:0]  empty_vec;
  logic [Ways-1:0]  vict_vec;
  logic [Ways-1:0]  cand_vec;
  logic [Ways-1:0]  sel_oh;
  logic [RankW-1:0] limit;
  logic             any_empty;

  always_comb begin
    for (int w = 0; w < Ways; w++) begin
      v[w] = row_i[w*LineW + TagW + RankW];
      t[w] = row_i[w*LineW + RankW +: TagW];
      r[w] = row_i[w*LineW +: RankW];
      in_use[w]    = (32'(w) < 32'(n_i));
      hit_vec[w]   = in_use[w] && v[w] && (t[w] == tag_i);
      empty_vec[w] = in_use[w] && !v[w];
    end
  end

  always_comb begin
    for (int w = 0; w < Ways; w++) begin
      vict_vec[w] = in_use[w];
      for (int j = 0; j < Ways; j++) begin
        if (in_use[j] && (j < w) && !(r[j] < r[w])) begin
          vict_vec[w] = 1'b0;
        end
        if (in_use[j] && (j > w) && (r[j] > r[w])) begin
          vict_vec[w] = 1'b0;
        end
      end
    end
  end

  assign hit_o     = |hit_vec;
  assign any_empty = |empty_vec;
  assign evict_o   = !hit_o && !any_empty;
  assign cand_vec  = hit_o ? hit_vec : (any_empty ? empty_vec : vict_vec);

  always_comb begin
    sel_oh = '0;
    for (int w = Ways - 1; w >= 0; w--) begin
      if (cand_vec[w]) begin
        sel_oh    = '0;
        sel_oh[w] = 1'b1;
      end
    end
  end

  always_comb begin
    limit = '0;
    if (!hit_o && any_empty) begin
      limit = RankW'(Ways - 1);
    end else begin
      for (int w = 0; w < Ways; w++) begin
        if (sel_oh[w]) begin
          limit = r[w];
        end
      end
    end
  end

  always_comb begin
    for (int w = 0; w < Ways; w++) begin
      if (sel_oh[w]) begin
        row_o[w*LineW +: LineW] = {1'b1, tag_i, {RankW{1'b0}}};
      end else if (in_use[w] && v[w] && (r[w] < limit)) begin
        row_o[w*LineW +: LineW] = {v[w], t[w], r[w] + RankW'(1)};
      end else begin
        row_o[w*LineW +: LineW] = row_i[w*LineW +: LineW];
      end
    end
  end

endmodule

FILE: hw/rtl/salct_stats.sv
// ----------------------------------------------------------------------------
// salct_stats
// Saturating hit, miss and eviction totals.
// ----------------------------------------------------------------------------
module salct_stats (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         upd_en_i,
  input  salct_pkg::upd_t              upd_i,
  output logic [salct_pkg::CountW-1:0] hits_o,
  output logic [salct_pkg::CountW-1:0] misses_o,
  output logic [salct_pkg::CountW-1:0] evicts_o
);

  localparam int unsigned W = salct_pkg::CountW;

  logic [W-1:0] hits_q, hits_d;
  logic [W-1:0] misses_q, misses_d;
  logic [W-1:0] evicts_q, evicts_d;
  logic [1:0]   hit_inc;
  logic [W:0]   hit_sum;
  logic [W:0]   miss_sum;
  logic [W:0]   evict_sum;

  always_comb begin
    if (upd_i.hit) begin
      hit_inc = upd_i.modify ? 2'd2 : 2'd1;
    end else begin
      hit_inc = upd_i.modify ? 2'd1 : 2'd0;
    end
    hit_sum   = {1'b0, hits_q} + (W+1)'(hit_inc);
    miss_sum  = {1'b0, misses_q} + (W+1)'(!upd_i.hit);
    evict_sum = {1'b0, evicts_q} + (W+1)'(upd_i.evict);
    hits_d    = hit_sum[W] ? '1 : hit_sum[W-1:0];
    misses_d  = miss_sum[W] ? '1 : miss_sum[W-1:0];
    evicts_d  = evict_sum[W] ? '1 : evict_sum[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q   <= '0;
      misses_q <= '0;
      evicts_q <= '0;
    end else if (upd_en_i) begin
      hits_q   <= hits_d;
      misses_q <= misses_d;
      evicts_q <= evicts_d;
    end
  end

  assign hits_o   = hits_q;
  assign misses_o = misses_q;
  assign evicts_o = evicts_q;

endmodule

FILE: hw/rtl/set_assoc_lru_cache_tracker.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tracker
// A result is registered once its set row has been read from the set memory
// and compared; it waits while the previous result is still held at the output.
// No new access is taken until the current one has done the read-modify-write
// of its set row in the set memory (read, then compare and write back).
// Instruction fetches are taken and dropped with no result.
// Reset sets the configuration to its defaults and clears totals and the
// per-set valid bits at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tracker #(
  parameter int unsigned MAX_SET_BITS = 6,
  parameter int unsigned WAYS         = 4,
  parameter int unsigned ADDR_BITS    = 48
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [salct_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [salct_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       op_i,
  input  logic [ADDR_BITS-1:0]             address_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             was_hit_o,
  output logic                             was_evicted_o,
  output logic [salct_pkg::CountW-1:0]     hit_total_o,
  output logic [salct_pkg::CountW-1:0]     miss_total_o,
  output logic [salct_pkg::CountW-1:0]     eviction_total_o
);

  localparam int unsigned NumSets = 1 << MAX_SET_BITS;
  localparam int unsigned SetW    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned RankW   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned NumW    = $clog2(WAYS + 1);
  localparam int unsigned LineW   = 1 + ADDR_BITS + RankW;
  localparam int unsigned RowW    = WAYS * LineW;

  localparam logic StIdle   = 1'b0;
  localparam logic StLookup = 1'b1;

  logic state_q, state_d;

  logic [2:0] set_bits_q;
  logic [4:0] off_bits_q;
  logic [2:0] ways_q;

  logic [2:0]           s_cl;
  logic [NumW-1:0]      n_cl;
  logic [ADDR_BITS-1:0] shifted;
  logic [5:0]           shamt;
  logic [SetW-1:0]      set_idx;
  logic [ADDR_BITS-1:0] tag;

  logic [SetW-1:0]      set_q;
  logic [ADDR_BITS-1:0] tag_q;
  logic [NumW-1:0]      n_q;
  logic                 modify_q;

  logic                 in_xfer;
  logic                 rd_en;
  logic                 can_load;
  logic                 do_load;
  logic [RowW-1:0]      rd_row;
  logic [RowW-1:0]      wr_row;
  logic                 lru_hit;
  logic                 lru_evict;
  salct_pkg::upd_t      upd;

  logic out_valid_q, out_valid_d;
  logic hit_q;
  logic evict_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q <= 3'd0;
      off_bits_q <= 5'd0;
      ways_q     <= 3'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        salct_pkg::CFG_SET_BITS: set_bits_q <= cfg_wdata_i[2:0];
        salct_pkg::CFG_OFF_BITS: off_bits_q <= cfg_wdata_i;
        salct_pkg::CFG_WAYS:     ways_q     <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    s_cl = (32'(set_bits_q) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits_q;
    if (ways_q == 3'd0) begin
      n_cl = NumW'(1);
    end else if (32'(ways_q) > WAYS) begin
      n_cl = NumW'(WAYS);
    end else begin
      n_cl = NumW'(ways_q);
    end
    shifted = address_i >> off_bits_q;
    shamt   = 6'(s_cl) + 6'(off_bits_q);
    tag     = address_i >> shamt;
    for (int b = 0; b < SetW; b++) begin
      set_idx[b] = shifted[b] && (b < 32'(s_cl));
    end
  end

  assign in_ready_o = (state_q == StIdle);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign rd_en      = in_xfer && (op_i != salct_pkg::OP_FETCH);
  assign can_load   = !out_valid_q || out_ready_i;
  assign do_load    = (state_q == StLookup) && can_load;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:   if (rd_en) state_d = StLookup;
      StLookup: if (can_load) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      set_q    <= set_idx;
      tag_q    <= tag;
      n_q      <= n_cl;
      modify_q <= (op_i == salct_pkg::OP_MODIFY);
    end
    if (do_load) begin
      hit_q   <= lru_hit;
      evict_q <= lru_evict;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (do_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  salct_set_mem #(
    .NumSets(NumSets),
    .IdxW   (SetW),
    .RowW   (RowW)
  ) u_set_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (rd_en),
    .rd_idx_i(set_idx),
    .rd_row_o(rd_row),
    .wr_en_i (do_load),
    .wr_idx_i(set_q),
    .wr_row_i(wr_row)
  );

  salct_lru #(
    .Ways (WAYS),
    .TagW (ADDR_BITS),
    .RankW(RankW),
    .NumW (NumW)
  ) u_lru (
    .row_i  (rd_row),
    .tag_i  (tag_q),
    .n_i    (n_q),
    .row_o  (wr_row),
    .hit_o  (lru_hit),
    .evict_o(lru_evict)
  );

  assign upd.hit    = lru_hit;
  assign upd.evict  = lru_evict;
  assign upd.modify = modify_q;

  salct_stats u_stats (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .upd_en_i(do_load),
    .upd_i   (upd),
    .hits_o  (hit_total_o),
    .misses_o(miss_total_o),
    .evicts_o(eviction_total_o)
  );

  assign out_valid_o   = out_valid_q;
  assign was_hit_o     = hit_q;
  assign was_evicted_o = evict_q;

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the set-associative LRU cache tracker. A short
// directed access table is walked first, then randomized phases sweep the
// set, offset and associativity settings. Each result is scored against a bench
// LRU predictor or a checked row, mostly under random valid/ready throttling.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned MaxSetBits   = 6;
  localparam int unsigned Ways         = 4;
  localparam int unsigned AddrBits     = 48;
  localparam int unsigned Depth        = (1 << MaxSetBits) * Ways;
  localparam int unsigned NumPhases    = 12;
  localparam int unsigned PhaseItems   = 128;
  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned SettleCycles = 4;

  localparam bit [4:0] PhaseSet  [NumPhases] = '{0, 7, 6, 3, 1, 2, 6, 5, 4, 7, 0, 2};
  localparam bit [4:0] PhaseOff  [NumPhases] = '{0, 31, 16, 4, 5, 0, 12, 6, 2, 3, 31, 7};
  localparam bit [4:0] PhaseWays [NumPhases] = '{1, 4, 0, 2, 7, 3, 4, 5, 1, 4, 2, 6};

  typedef struct packed {
    logic        hit;
    logic        evicted;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] evictions;
  } outcome_t;

  typedef struct packed {
    logic                           is_write;
    logic [salct_pkg::CfgIdxW-1:0]  reg_idx;
    logic [salct_pkg::CfgDataW-1:0] reg_val;
    salct_pkg::op_e                 op;
    logic [AddrBits-1:0]            addr;
    logic                           typed;
    outcome_t                       want;
  } plan_row_t;

  logic                           clk_i;
  logic                           rst_ni      = 1'b0;
  logic                           cfg_we_i    = 1'b0;
  logic [salct_pkg::CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [salct_pkg::CfgDataW-1:0] cfg_wdata_i = '0;
  logic                           in_valid_i  = 1'b0;
  logic                           in_ready_o;
  logic [1:0]                     op_i        = '0;
  logic [AddrBits-1:0]            address_i   = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic                           was_hit_o;
  logic                           was_evicted_o;
  logic [salct_pkg::CountW-1:0]   hit_total_o;
  logic [salct_pkg::CountW-1:0]   miss_total_o;
  logic [salct_pkg::CountW-1:0]   eviction_total_o;

  logic                cur_typed = 1'b0;
  outcome_t            cur_want  = '0;

  bit                  line_valid [Depth];
  bit [AddrBits-1:0]   line_tag   [Depth];
  bit [1:0]            line_rank  [Depth];
  bit [2:0]            cfg_set_bits = 3'd0;
  bit [4:0]            cfg_off_bits = 5'd0;
  bit [2:0]            cfg_ways     = 3'd1;
  bit [31:0]           hits_seen      = '0;
  bit [31:0]           misses_seen    = '0;
  bit [31:0]           evictions_seen = '0;

  outcome_t            pending_results [$];
  plan_row_t           access_plan [$];
  logic [AddrBits-1:0] tag_pool [6];
  int unsigned         err_count   = 0;
  int unsigned         idle_cycles = 0;
  int unsigned         tx_idle     = 11;
  int unsigned         rx_idle     = 75;

  set_assoc_lru_cache_tracker #(
    .MAX_SET_BITS(MaxSetBits),
    .WAYS        (Ways),
    .ADDR_BITS   (AddrBits)
  ) dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic bit [31:0] sat_add(bit [31:0] a, bit [31:0] b);
    bit [32:0] sum;
    sum = a + b;
    return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  endfunction

  function automatic int unsigned eff_set_bits(bit [2:0] v);
    return (v > MaxSetBits) ? MaxSetBits : v;
  endfunction

  function automatic int unsigned eff_ways(bit [2:0] v);
    return (v == 0) ? 1 : ((v > Ways) ? Ways : v);
  endfunction

  function automatic void age_newer(int unsigned base, int unsigned n, int unsigned skip,
                                    bit [1:0] limit);
    for (int unsigned w = 0; w < n; w++) begin
      if (w != skip && line_valid[base + w] && line_rank[base + w] < limit) begin
        line_rank[base + w]++;
      end
    end
  endfunction

  function automatic outcome_t cache_access(salct_pkg::op_e op, logic [AddrBits-1:0] addr);
    int unsigned         s;
    int unsigned         n;
    int unsigned         base;
    int unsigned         victim;
    int                  hit_way;
    int                  empty_way;
    logic [AddrBits-1:0] set_no;
    logic [AddrBits-1:0] tag;
    outcome_t            res;
    s         = eff_set_bits(cfg_set_bits);
    n         = eff_ways(cfg_ways);
    set_no    = (addr >> cfg_off_bits) & ((48'd1 << s) - 48'd1);
    tag       = addr >> (s + cfg_off_bits);
    base      = 32'(set_no) * Ways;
    hit_way   = -1;
    empty_way = -1;
    res       = '0;
    for (int unsigned w = 0; w < n; w++) begin
      if (line_valid[base + w]) begin
        if (hit_way < 0 && line_tag[base + w] == tag) hit_way = w;
      end else if (empty_way < 0) begin
        empty_way = w;
      end
    end
    if (hit_way >= 0) begin
      res.hit = 1'b1;
      age_newer(base, n, hit_way, line_rank[base + hit_way]);
      line_rank[base + hit_way] = '0;
    end else if (empty_way >= 0) begin
      for (int unsigned w = 0; w < n; w++) begin
        if (line_valid[base + w] && line_rank[base + w] < Ways - 1) line_rank[base + w]++;
      end
      line_valid[base + empty_way] = 1'b1;
      line_tag[base + empty_way]   = tag;
      line_rank[base + empty_way]  = '0;
    end else begin
      victim = 0;
      for (int unsigned w = 1; w < n; w++) begin
        if (line_rank[base + w] > line_rank[base + victim]) victim = w;
      end
      age_newer(base, n, victim, line_rank[base + victim]);
      line_tag[base + victim]  = tag;
      line_rank[base + victim] = '0;
      res.evicted = 1'b1;
    end
    if (res.hit) begin
      hits_seen = sat_add(hits_seen, (op == salct_pkg::OP_MODIFY) ? 32'd2 : 32'd1);
    end else begin
      misses_seen = sat_add(misses_seen, 32'd1);
      if (res.evicted) evictions_seen = sat_add(evictions_seen, 32'd1);
      if (op == salct_pkg::OP_MODIFY) hits_seen = sat_add(hits_seen, 32'd1);
    end
    res.hits      = hits_seen;
    res.misses    = misses_seen;
    res.evictions = evictions_seen;
    return res;
  endfunction

  function automatic void plan_access(salct_pkg::op_e op, logic [AddrBits-1:0] addr);
    plan_row_t row;
    row      = '0;
    row.op   = op;
    row.addr = addr;
    access_plan.push_back(row);
  endfunction

  function automatic void plan_checked(salct_pkg::op_e op, logic [AddrBits-1:0] addr,
                                       logic hit, logic evicted, logic [31:0] hits,
                                       logic [31:0] misses, logic [31:0] evictions);
    plan_row_t row;
    row                = '0;
    row.op             = op;
    row.addr           = addr;
    row.typed          = 1'b1;
    row.want.hit       = hit;
    row.want.evicted   = evicted;
    row.want.hits      = hits;
    row.want.misses    = misses;
    row.want.evictions = evictions;
    access_plan.push_back(row);
  endfunction

  function automatic void plan_write(logic [salct_pkg::CfgIdxW-1:0] idx,
                                     logic [salct_pkg::CfgDataW-1:0] val);
    plan_row_t row;
    row          = '0;
    row.is_write = 1'b1;
    row.reg_idx  = idx;
    row.reg_val  = val;
    access_plan.push_back(row);
  endfunction

  function automatic logic [AddrBits-1:0] pick_address(int unsigned s, int unsigned off,
                                                       int unsigned pool_n);
    logic [AddrBits-1:0] noise;
    logic [AddrBits-1:0] off_mask;
    logic [AddrBits-1:0] set_mask;
    noise = {16'($urandom), $urandom};
    if ($urandom_range(0, 99) < 10) return noise;
    off_mask = (48'd1 << off) - 48'd1;
    set_mask = (48'd1 << s) - 48'd1;
    return (tag_pool[$urandom_range(0, pool_n - 1)] << (s + off))
         | ((48'($urandom_range(0, 3)) & set_mask) << off)
         | (noise & off_mask);
  endfunction

  task automatic log_error(string msg);
    err_count++;
    $display("error: %s", msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) log_error($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  task automatic send_access(salct_pkg::op_e op, logic [AddrBits-1:0] addr, logic typed,
                             outcome_t want);
    while ($urandom_range(0, 99) < tx_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    address_i  <= addr;
    cur_typed  <= typed;
    cur_want   <= want;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // drop valid and hold until every expected result is back
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [salct_pkg::CfgIdxW-1:0] idx,
                           logic [salct_pkg::CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= rx_idle);
  end

  always @(posedge clk_i) begin : track
    outcome_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          salct_pkg::CFG_SET_BITS: cfg_set_bits = cfg_wdata_i[2:0];
          salct_pkg::CFG_OFF_BITS: cfg_off_bits = cfg_wdata_i;
          salct_pkg::CFG_WAYS:     cfg_ways     = cfg_wdata_i[2:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o && salct_pkg::op_e'(op_i) != salct_pkg::OP_FETCH) begin
        want = cache_access(salct_pkg::op_e'(op_i), address_i);
        pending_results.push_back(cur_typed ? cur_want : want);
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          log_error("result transfer with nothing expected");
        end else begin
          want = pending_results.pop_front();
          check_field("was_hit", 32'(was_hit_o), 32'(want.hit));
          check_field("was_evicted", 32'(was_evicted_o), 32'(want.evicted));
          check_field("hit_total", hit_total_o, want.hits);
          check_field("miss_total", miss_total_o, want.misses);
          check_field("eviction_total", eviction_total_o, want.evictions);
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
  end

  initial begin
    wait (rst_ni === 1'b1);
    while (idle_cycles < StallLimit) @(posedge clk_i);
    $display("status: fail");
    $finish;
  end

  initial begin
    int unsigned    sent;
    int unsigned    s_eff;
    int unsigned    w_eff;
    salct_pkg::op_e op;

    plan_checked(salct_pkg::OP_LOAD,   48'd0,              1'b0, 1'b0, 0, 1, 0);
    plan_checked(salct_pkg::OP_LOAD,   48'd0,              1'b1, 1'b0, 1, 1, 0);
    plan_checked(salct_pkg::OP_STORE,  48'hFFFF_FFFF_FFFF, 1'b0, 1'b1, 1, 2, 1);
    plan_checked(salct_pkg::OP_MODIFY, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 3, 2, 1);
    plan_access(salct_pkg::OP_FETCH,   48'hFFFF_FFFF_FFFF);
    plan_checked(salct_pkg::OP_MODIFY, 48'd0,              1'b0, 1'b1, 4, 3, 2);
    plan_access(salct_pkg::OP_FETCH,   48'd0);
    plan_checked(salct_pkg::OP_LOAD,   48'd0,              1'b1, 1'b0, 5, 3, 2);
    plan_write(salct_pkg::CFG_SET_BITS, 5'd7);
    plan_write(salct_pkg::CFG_OFF_BITS, 5'd31);
    plan_write(salct_pkg::CFG_WAYS, 5'd4);
    plan_access(salct_pkg::OP_LOAD,   48'd1 << 37);
    plan_access(salct_pkg::OP_STORE,  48'd2 << 37);
    plan_access(salct_pkg::OP_LOAD,   (48'd3 << 37) | 48'h7FFF_FFFF);
    plan_access(salct_pkg::OP_LOAD,   48'd0);
    plan_access(salct_pkg::OP_LOAD,   48'd4 << 37);
    plan_access(salct_pkg::OP_MODIFY, (48'd1 << 37) | (48'd63 << 31));
    plan_access(salct_pkg::OP_MODIFY, 48'd2 << 37);
    plan_write(salct_pkg::CFG_WAYS, 5'd0);
    plan_access(salct_pkg::OP_LOAD,   48'd5 << 37);
    plan_write(salct_pkg::CFG_WAYS, 5'd7);
    plan_access(salct_pkg::OP_LOAD,   48'd3 << 37);
    plan_write(salct_pkg::CFG_WAYS, 5'd2);
    plan_access(salct_pkg::OP_STORE,  48'd4 << 37);
    plan_access(salct_pkg::OP_LOAD,   48'd6 << 37);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (access_plan[i]) begin
      if (access_plan[i].is_write) begin
        settle();
        write_reg(access_plan[i].reg_idx, access_plan[i].reg_val);
        cfg_we_i <= 1'b0;
      end else begin
        send_access(access_plan[i].op, access_plan[i].addr, access_plan[i].typed,
                    access_plan[i].want);
      end
    end

    for (int unsigned p = 0; p < NumPhases; p++) begin
      if (p < 4) begin
        tx_idle = 11;
        rx_idle = 75;
      end else if (p < 8) begin
        tx_idle = 75;
        rx_idle = 11;
      end else begin
        tx_idle = 0;
        rx_idle = 0;
      end
      settle();
      write_reg(salct_pkg::CFG_SET_BITS, PhaseSet[p]);
      write_reg(salct_pkg::CFG_OFF_BITS, PhaseOff[p]);
      write_reg(salct_pkg::CFG_WAYS, PhaseWays[p]);
      cfg_we_i <= 1'b0;
      s_eff = eff_set_bits(PhaseSet[p][2:0]);
      w_eff = eff_ways(PhaseWays[p][2:0]);
      for (int unsigned i = 0; i < 6; i++) begin
        tag_pool[i] = ($urandom_range(0, 3) == 0) ? {16'($urandom), $urandom} : 48'(i);
      end
      sent = 0;
      while (sent < PhaseItems) begin
        op = ($urandom_range(0, 99) < 8) ? salct_pkg::OP_FETCH
                                         : salct_pkg::op_e'($urandom_range(0, 2));
        send_access(op, pick_address(s_eff, PhaseOff[p], w_eff + 2), 1'b0, '0);
        sent++;
      end
    end

    settle();
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
